@@ design/sot_pkg.sv @@
// Shared types and constants for the slot ownership table.
`default_nettype none

package sot_pkg;

  // Table size and the address width that follows from it.
  localparam int unsigned SLOT_COUNT_MAX = 64;
  localparam int unsigned SLOT_IDX_W = (SLOT_COUNT_MAX > 1) ? $clog2(SLOT_COUNT_MAX) : 1;

  // Field widths fixed by the interface.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned SEQ_W    = 64;
  localparam int unsigned FLAGS_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned SLOTS_W  = 7;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOTS_IN_USE     = 1'd0,
    CFG_PAYLOAD_CAPACITY = 1'd1
  } cfg_reg_e;

  // Command codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN_WRITE    = 3'd0,
    KIND_PUBLISH        = 3'd1,
    KIND_ABORT          = 3'd2,
    KIND_BEGIN_READ     = 3'd3,
    KIND_READ_MATCHING  = 3'd4,
    KIND_RELEASE        = 3'd5,
    KIND_QUERY          = 3'd6
  } kind_e;

  // Status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_STALE     = 3'd3,
    ST_ACQUIRED  = 3'd4,
    ST_INVALID   = 3'd5,
    ST_BAD_STATE = 3'd6
  } status_e;

  // Slot handshake phases.
  typedef enum logic [PHASE_W-1:0] {
    PH_EMPTY   = 2'd0,
    PH_WRITING = 2'd1,
    PH_READY   = 2'd2,
    PH_READING = 2'd3
  } phase_e;

  // Request payload.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] slot_sel;
    logic [SIZE_W-1:0]  payload_bytes;
    logic [SEQ_W-1:0]   sequence_number;
    logic [FLAGS_W-1:0] slot_flags_in;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PHASE_W-1:0]  slot_state_out;
  } rsp_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    phase_e            phase;
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Decision of the command logic for one request.
  typedef struct packed {
    logic    we;
    entry_t  entry;
    status_e status;
    phase_e  phase_out;
  } cmd_out_t;

endpackage

`default_nettype wire

@@ design/sot_entry_store.sv @@
// Slot entry memory with registered read and per-slot valid bits.
`default_nettype none

module sot_entry_store (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          rd_en_i,
  input  wire [sot_pkg::SLOT_IDX_W-1:0] rd_addr_i,
  input  wire                          wr_en_i,
  input  wire [sot_pkg::SLOT_IDX_W-1:0] wr_addr_i,
  input  sot_pkg::entry_t              wr_data_i,
  output sot_pkg::entry_t              rd_data_o,
  output logic                         rd_hit_o
);
  import sot_pkg::*;

  entry_t                    mem_q [SLOT_COUNT_MAX];
  entry_t                    rd_data_q;
  logic [SLOT_COUNT_MAX-1:0] written_q;
  logic                      rd_hit_q;

  // Memory array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Written flags; a read of an entry never written gives rd_hit_o low.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_hit_o  = rd_hit_q;

endmodule

`default_nettype wire

@@ design/sot_cmd_logic.sv @@
// Per-command decision logic: status, new entry and write-back for one slot.
`default_nettype none

module sot_cmd_logic (
  input  wire                         in_range_i,
  input  wire [sot_pkg::KIND_W-1:0]   kind_i,
  input  wire [sot_pkg::SIZE_W-1:0]   bytes_i,
  input  wire [sot_pkg::SEQ_W-1:0]    seq_i,
  input  wire [sot_pkg::SIZE_W-1:0]   capacity_i,
  input  sot_pkg::entry_t             cur_i,
  output sot_pkg::cmd_out_t           cmd_o
);
  import sot_pkg::*;

  always_comb begin
    cmd_o.we        = 1'b0;
    cmd_o.entry     = cur_i;
    cmd_o.status    = ST_DONE;
    cmd_o.phase_out = cur_i.phase;

    if (!in_range_i) begin
      // Out-of-range slot wins over every other answer.
      cmd_o.status    = ST_INVALID;
      cmd_o.phase_out = PH_EMPTY;
    end else begin
      unique case (kind_e'(kind_i))
        KIND_BEGIN_WRITE: begin
          if (cur_i.phase == PH_EMPTY) begin
            cmd_o.we          = 1'b1;
            cmd_o.entry.phase = PH_WRITING;
          end else begin
            cmd_o.status = ST_REFUSED;
          end
        end
        KIND_PUBLISH: begin
          if (bytes_i > capacity_i) begin
            cmd_o.status = ST_INVALID;
          end else if (cur_i.phase != PH_WRITING) begin
            cmd_o.status = ST_BAD_STATE;
          end else begin
            cmd_o.we          = 1'b1;
            cmd_o.entry.phase = PH_READY;
            cmd_o.entry.seq   = seq_i;
            cmd_o.entry.size  = bytes_i;
          end
        end
        KIND_ABORT: begin
          // The sequence number survives an abort.
          if (cur_i.phase == PH_WRITING) begin
            cmd_o.we          = 1'b1;
            cmd_o.entry.phase = PH_EMPTY;
            cmd_o.entry.size  = '0;
          end else begin
            cmd_o.status = ST_REFUSED;
          end
        end
        KIND_BEGIN_READ: begin
          if (cur_i.phase == PH_READY) begin
            cmd_o.we          = 1'b1;
            cmd_o.entry.phase = PH_READING;
          end else begin
            cmd_o.status = ST_REFUSED;
          end
        end
        KIND_READ_MATCHING: begin
          if (cur_i.phase != PH_READY) begin
            cmd_o.status = ST_NOT_READY;
          end else if (cur_i.seq != seq_i || cur_i.size != bytes_i) begin
            cmd_o.status = ST_STALE;
          end else begin
            cmd_o.we          = 1'b1;
            cmd_o.entry.phase = PH_READING;
            cmd_o.status      = ST_ACQUIRED;
          end
        end
        KIND_RELEASE: begin
          if (cur_i.phase == PH_READING) begin
            cmd_o.we          = 1'b1;
            cmd_o.entry.phase = PH_EMPTY;
            cmd_o.entry.size  = '0;
          end else begin
            cmd_o.status = ST_BAD_STATE;
          end
        end
        KIND_QUERY: begin
          cmd_o.status = ST_DONE;
        end
        default: begin
          cmd_o.status = ST_INVALID;
        end
      endcase
    end

    cmd_o.phase_out = (in_range_i) ? cmd_o.entry.phase : PH_EMPTY;
  end

endmodule

`default_nettype wire

@@ design/slot_ownership_table_unit.sv @@
// Slot ownership table: top level with request pipeline, forwarding and output register.
//
// Usage: each request on req_i names one slot and a command; the block answers
// each request with exactly one response on rsp_o, in request order. Both
// channels use valid/ready; a request is taken when req_valid_i and
// req_ready_o are high at a rising edge, a response when rsp_valid_o and
// rsp_ready_i are.
// Path: a taken request passes the command stage register and then the output
// register, whose valid bit drives rsp_valid_o.
// Throughput: one request per cycle while the output is not stalled. The slot memory is
// read in the cycle a request is taken and written back as it leaves the command stage;
// a request to the slot written at that edge takes the new entry from a bypass register.
// Stall: while a response waits in the output register and rsp_ready_i is
// low, one more request is taken into the command stage, which then holds,
// and req_ready_o drops until the response leaves.
// Reset: rst_ni clears the per-slot written flags at once, so every slot
// reads empty with zero sequence and size; no clearing pass is needed.
// Configuration writes on cfg_we_i take effect at the next edge; the user must make
// them only while no request is in flight, as the block does not enforce it.
`default_nettype none

module slot_ownership_table_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [sot_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [sot_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                          req_valid_i,
  output logic                         req_ready_o,
  input  sot_pkg::req_t                req_i,
  output logic                         rsp_valid_o,
  input  wire                          rsp_ready_i,
  output sot_pkg::rsp_t                rsp_o
);
  import sot_pkg::*;

  // Configuration registers.
  logic [SLOTS_W-1:0] slots_q;
  logic [SIZE_W-1:0]  capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q    <= SLOTS_W'(64);
      capacity_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SLOTS_IN_USE:     slots_q    <= cfg_wdata_i[SLOTS_W-1:0];
        CFG_PAYLOAD_CAPACITY: capacity_q <= cfg_wdata_i[SIZE_W-1:0];
        default:              slots_q    <= slots_q;
      endcase
    end
  end

  // Range check against the active slot count, clamped to the table size.
  logic [LIMIT_W-1:0] slots_ext;
  logic [LIMIT_W-1:0] limit;
  logic               req_in_range;

  assign slots_ext    = LIMIT_W'(slots_q);
  assign limit        = (slots_ext > LIMIT_W'(SLOT_COUNT_MAX)) ? LIMIT_W'(SLOT_COUNT_MAX)
                                                               : slots_ext;
  assign req_in_range = LIMIT_W'(req_i.slot_sel) < limit;

  // Command stage control.
  logic                  a_valid_q;
  logic                  a_in_range_q;
  logic [SLOT_IDX_W-1:0] a_idx_q;
  logic [KIND_W-1:0]     a_kind_q;
  logic [SIZE_W-1:0]     a_bytes_q;
  logic [SEQ_W-1:0]      a_seq_q;
  logic                  a_adv;
  logic                  req_take;
  logic [SLOT_IDX_W-1:0] req_idx;

  assign a_adv       = !rsp_valid_o || rsp_ready_i;
  assign req_ready_o = !a_valid_q || a_adv;
  assign req_take    = req_valid_i && req_ready_o;
  assign req_idx     = req_i.slot_sel[SLOT_IDX_W-1:0];

  // Slot memory.
  entry_t   rd_data;
  logic     rd_hit;
  cmd_out_t cmd;
  logic     wr_en;

  assign wr_en = a_valid_q && a_adv && cmd.we;

  sot_entry_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (req_take),
    .rd_addr_i (req_idx),
    .wr_en_i   (wr_en),
    .wr_addr_i (a_idx_q),
    .wr_data_i (cmd.entry),
    .rd_data_o (rd_data),
    .rd_hit_o  (rd_hit)
  );

  // Bypass for a request that reads the slot being written at the same edge.
  logic   fwd_hit_q;
  entry_t fwd_q;
  entry_t cur_entry;

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      fwd_q <= cmd.entry;
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      cur_entry = fwd_q;
    end else if (rd_hit) begin
      cur_entry = rd_data;
    end else begin
      cur_entry = '{phase: PH_EMPTY, seq: '0, size: '0};
    end
  end

  // Command decision.
  sot_cmd_logic u_cmd (
    .in_range_i (a_in_range_q),
    .kind_i     (a_kind_q),
    .bytes_i    (a_bytes_q),
    .seq_i      (a_seq_q),
    .capacity_i (capacity_q),
    .cur_i      (cur_entry),
    .cmd_o      (cmd)
  );

  // Command stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (req_take) begin
        a_valid_q <= 1'b1;
        fwd_hit_q <= wr_en && (req_idx == a_idx_q);
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      a_in_range_q <= req_in_range;
      a_idx_q      <= req_idx;
      a_kind_q     <= req_i.kind;
      a_bytes_q    <= req_i.payload_bytes;
      a_seq_q      <= req_i.sequence_number;
    end
  end

  // Output register.
  logic rsp_valid_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (a_adv) begin
      rsp_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_adv) begin
      rsp_q.status         <= cmd.status;
      rsp_q.slot_state_out <= cmd.phase_out;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Out-of-range requests answer invalid with an empty phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_adv && !a_in_range_q) |=>
      (rsp_valid_o && rsp_o.status == ST_INVALID && rsp_o.slot_state_out == PH_EMPTY))
    else $error("out-of-range request did not answer invalid");

  // The memory is only written by an in-range request leaving the command stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (a_valid_q && a_in_range_q))
    else $error("slot memory written without an in-range request");

  // The bypass is only armed by a write at the edge the request was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_hit_q) |-> $past(wr_en && req_take))
    else $error("bypass armed without a same-edge write");

  // A held command stage blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && rsp_valid_o && !rsp_ready_i) |-> !req_ready_o)
    else $error("request taken while command stage is stalled");

endmodule

`default_nettype wire

@@ verif/slot_ownership_table_unit_tb.sv @@
// Testbench for the slot ownership table: directed and random traffic checked by a predictor.
`timescale 1ns / 100ps

module slot_ownership_table_unit_tb;
  import sot_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned LIFECYCLES      = 4;
  localparam int unsigned LONG_STALL      = 300;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  // Steps of one writer/reader lifecycle on a slot.
  localparam int unsigned GEN_CLAIM  = 0;
  localparam int unsigned GEN_FILL   = 1;
  localparam int unsigned GEN_READ   = 2;
  localparam int unsigned GEN_RETURN = 3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req_data = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp_data;

  // Requests waiting for the driver and responses the table still owes.
  req_t requests_to_send[$];
  rsp_t answers_due[$];

  logic        req_taken = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned rx_stall_left = 0;
  int unsigned fail_count = 0;

  // Predictor copy of the registers and of the slot table.
  logic [SLOTS_W-1:0] cfg_slots;
  logic [SIZE_W-1:0]  cfg_capacity;
  phase_e             tbl_phase [SLOT_COUNT_MAX];
  logic [SEQ_W-1:0]   tbl_seq   [SLOT_COUNT_MAX];
  logic [SIZE_W-1:0]  tbl_size  [SLOT_COUNT_MAX];
  logic [FLAGS_W-1:0] tbl_flags [SLOT_COUNT_MAX];

  // State of the lifecycles the random traffic interleaves.
  logic [INDEX_W-1:0] gen_slot [LIFECYCLES];
  int unsigned        gen_step [LIFECYCLES];
  logic [SEQ_W-1:0]   gen_seq  [LIFECYCLES];
  logic [SIZE_W-1:0]  gen_size [LIFECYCLES];

  slot_ownership_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req_data),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_data)
  );

  always #5 clk_i = ~clk_i;

  // Slot count as the table applies it: values above the table size saturate.
  function automatic int unsigned active_slots();
    return (cfg_slots > SLOT_COUNT_MAX) ? SLOT_COUNT_MAX : cfg_slots;
  endfunction

  // Applies one command to the predicted table and returns the answer it must give.
  function automatic rsp_t apply_slot_command(req_t r);
    rsp_t        o;
    int unsigned s;
    phase_e      ph;
    status_e     st;
    if (r.slot_sel >= active_slots()) begin
      o.status         = ST_INVALID;
      o.slot_state_out = PH_EMPTY;
      return o;
    end
    s  = r.slot_sel;
    ph = tbl_phase[s];
    case (r.kind)
      KIND_BEGIN_WRITE: begin
        if (ph == PH_EMPTY) begin
          ph = PH_WRITING;
          st = ST_DONE;
        end else begin
          st = ST_REFUSED;
        end
      end
      KIND_PUBLISH: begin
        if (r.payload_bytes > cfg_capacity) begin
          st = ST_INVALID;
        end else if (ph != PH_WRITING) begin
          st = ST_BAD_STATE;
        end else begin
          tbl_size[s]  = r.payload_bytes;
          tbl_seq[s]   = r.sequence_number;
          tbl_flags[s] = r.slot_flags_in;
          ph = PH_READY;
          st = ST_DONE;
        end
      end
      KIND_ABORT: begin
        if (ph == PH_WRITING) begin
          tbl_size[s]  = '0;
          tbl_flags[s] = '0;
          ph = PH_EMPTY;
          st = ST_DONE;
        end else begin
          st = ST_REFUSED;
        end
      end
      KIND_BEGIN_READ: begin
        if (ph == PH_READY) begin
          ph = PH_READING;
          st = ST_DONE;
        end else begin
          st = ST_REFUSED;
        end
      end
      KIND_READ_MATCHING: begin
        if (ph != PH_READY) begin
          st = ST_NOT_READY;
        end else if (tbl_seq[s] != r.sequence_number || tbl_size[s] != r.payload_bytes) begin
          st = ST_STALE;
        end else begin
          ph = PH_READING;
          st = ST_ACQUIRED;
        end
      end
      KIND_RELEASE: begin
        if (ph == PH_READING) begin
          tbl_size[s]  = '0;
          tbl_flags[s] = '0;
          ph = PH_EMPTY;
          st = ST_DONE;
        end else begin
          st = ST_BAD_STATE;
        end
      end
      KIND_QUERY: st = ST_DONE;
      default:    st = ST_INVALID;
    endcase
    tbl_phase[s]     = ph;
    o.status         = st;
    o.slot_state_out = ph;
    return o;
  endfunction

  // Picks a slot inside the active range, or any index when none is active.
  function automatic logic [INDEX_W-1:0] pick_live_slot();
    int unsigned n;
    n = active_slots();
    if (n == 0) return INDEX_W'($urandom_range(0, 255));
    return INDEX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic queue_request(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] slot,
                               logic [SIZE_W-1:0] bytes, logic [SEQ_W-1:0] seq,
                               logic [FLAGS_W-1:0] flags);
    req_t r;
    r.kind            = kind;
    r.slot_sel        = slot;
    r.payload_bytes   = bytes;
    r.sequence_number = seq;
    r.slot_flags_in   = flags;
    requests_to_send.push_back(r);
  endtask

  task automatic write_config(cfg_reg_e which, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= which;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (which == CFG_SLOTS_IN_USE) cfg_slots = data[SLOTS_W-1:0];
    else cfg_capacity = data[SIZE_W-1:0];
  endtask

  // Waits until every queued request is taken and every response has come back.
  // The check runs at the rising edge, where the driver never changes the request.
  task automatic wait_until_idle();
    do @(posedge clk_i);
    while (requests_to_send.size() != 0 || req_valid || answers_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Next request of one of the interleaved lifecycles: claim, fill, read, return.
  task automatic next_lifecycle_request(output req_t r);
    int unsigned c;
    int unsigned roll;
    bit          done_with_slot;
    c    = $urandom_range(0, LIFECYCLES - 1);
    roll = $urandom_range(0, 99);
    done_with_slot    = 1'b0;
    r.slot_sel        = gen_slot[c];
    r.payload_bytes   = $urandom;
    r.sequence_number = {$urandom, $urandom};
    r.slot_flags_in   = $urandom;
    case (gen_step[c])
      GEN_CLAIM: begin
        r.kind      = KIND_BEGIN_WRITE;
        gen_step[c] = GEN_FILL;
      end
      GEN_FILL: begin
        if (roll < 10) begin
          r.kind = KIND_ABORT;
          done_with_slot = 1'b1;
        end else if (roll < 16 && cfg_capacity != '1) begin
          // Oversized publish: the writer keeps the slot and tries again.
          r.kind          = KIND_PUBLISH;
          r.payload_bytes = $urandom_range(cfg_capacity + 1, 32'hFFFF_FFFF);
        end else begin
          r.kind          = KIND_PUBLISH;
          r.payload_bytes = $urandom_range(0, cfg_capacity);
          gen_size[c]     = r.payload_bytes;
          gen_seq[c]      = r.sequence_number;
          gen_step[c]     = GEN_READ;
        end
      end
      GEN_READ: begin
        if (roll < 45) begin
          r.kind      = KIND_BEGIN_READ;
          gen_step[c] = GEN_RETURN;
        end else if (roll < 88) begin
          r.kind            = KIND_READ_MATCHING;
          r.payload_bytes   = gen_size[c];
          r.sequence_number = gen_seq[c];
          gen_step[c]       = GEN_RETURN;
        end else begin
          // Reader with an outdated view: one bit of sequence or size is off.
          r.kind            = KIND_READ_MATCHING;
          r.payload_bytes   = gen_size[c];
          r.sequence_number = gen_seq[c];
          if (roll % 2 == 0) r.sequence_number[$urandom_range(0, SEQ_W - 1)] ^= 1'b1;
          else r.payload_bytes[$urandom_range(0, SIZE_W - 1)] ^= 1'b1;
        end
      end
      default: begin
        if (roll < 15) begin
          r.kind = KIND_QUERY;
        end else begin
          r.kind = KIND_RELEASE;
          done_with_slot = 1'b1;
        end
      end
    endcase
    if (done_with_slot) begin
      gen_step[c] = GEN_CLAIM;
      gen_slot[c] = pick_live_slot();
    end
  endtask

  task automatic run_random_phase(logic [CFG_DATA_W-1:0] slots, logic [CFG_DATA_W-1:0] cap,
                                  int unsigned tx_pct, int unsigned rx_pct, bit long_stall);
    req_t r;
    write_config(CFG_SLOTS_IN_USE, slots);
    write_config(CFG_PAYLOAD_CAPACITY, cap);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned c = 0; c < LIFECYCLES; c++) begin
      gen_step[c] = GEN_CLAIM;
      gen_slot[c] = pick_live_slot();
    end
    for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        // Noise: any command code, any index, any field values.
        r.kind            = KIND_W'($urandom_range(0, 7));
        r.slot_sel        = ($urandom_range(0, 1) == 0) ? pick_live_slot()
                                                        : INDEX_W'($urandom_range(0, 255));
        r.payload_bytes   = $urandom;
        r.sequence_number = {$urandom, $urandom};
        r.slot_flags_in   = $urandom;
      end else begin
        next_lifecycle_request(r);
      end
      requests_to_send.push_back(r);
    end
    if (long_stall) stall_requests++;
    wait_until_idle();
  endtask

  // Driver: offers the next request once the previous one is taken, with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        req_data  <= requests_to_send.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served  <= stall_served + 1;
      rx_stall_left <= LONG_STALL;
      rsp_ready     <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      rsp_ready     <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: checks each response against the oldest prediction, then predicts new requests.
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (answers_due.size() == 0) begin
          $error("response with no request outstanding: status %0d, slot_state_out %0d",
                 rsp_data.status, rsp_data.slot_state_out);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_data.status);
            fail_count++;
          end
          if (rsp_data.slot_state_out !== want.slot_state_out) begin
            $error("slot_state_out mismatch: expected %0d, actual %0d",
                   want.slot_state_out, rsp_data.slot_state_out);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) answers_due.push_back(apply_slot_command(req_data));
    end
  end

  // Stimulus: directed corner cases, then random phases over several register settings.
  initial begin
    cfg_slots    = 7'd64;
    cfg_capacity = 32'hFFFF_FFFF;
    for (int unsigned s = 0; s < SLOT_COUNT_MAX; s++) begin
      tbl_phase[s] = PH_EMPTY;
      tbl_seq[s]   = '0;
      tbl_size[s]  = '0;
      tbl_flags[s] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 24;
    rx_idle_pct = 63;

    // Every command but begin-write against an empty slot.
    queue_request(KIND_QUERY, 0, 0, 0, 0);
    queue_request(KIND_BEGIN_READ, 0, 0, 0, 0);
    queue_request(KIND_READ_MATCHING, 0, 0, 0, 0);
    queue_request(KIND_RELEASE, 0, 0, 0, 0);
    queue_request(KIND_ABORT, 0, 0, 0, 0);
    queue_request(KIND_PUBLISH, 0, 0, 0, 0);
    // Full cycle on the top slot with all-ones fields and both stale variants.
    queue_request(KIND_BEGIN_WRITE, 63, 0, 0, 0);
    queue_request(KIND_BEGIN_WRITE, 63, 0, 0, 0);
    queue_request(KIND_PUBLISH, 63, '1, '1, '1);
    queue_request(KIND_READ_MATCHING, 63, '1, 64'hFFFF_FFFF_FFFF_FFFE, 0);
    queue_request(KIND_READ_MATCHING, 63, 32'hFFFF_FFFE, '1, 0);
    queue_request(KIND_READ_MATCHING, 63, '1, '1, 0);
    queue_request(KIND_BEGIN_READ, 63, 0, 0, 0);
    queue_request(KIND_RELEASE, 63, 0, 0, 0);
    // Abort, then a zero-size publish read back without conditions.
    queue_request(KIND_BEGIN_WRITE, 5, 0, 0, 0);
    queue_request(KIND_ABORT, 5, 0, 0, 0);
    queue_request(KIND_BEGIN_WRITE, 5, 0, 0, 0);
    queue_request(KIND_PUBLISH, 5, 0, 0, 0);
    queue_request(KIND_BEGIN_READ, 5, 0, 0, 0);
    queue_request(KIND_RELEASE, 5, 0, 0, 0);
    // Indexes beyond the table and the unused command code on a busy slot.
    queue_request(KIND_QUERY, 64, 0, 0, 0);
    queue_request(KIND_BEGIN_WRITE, 255, 0, 0, 0);
    queue_request(KIND_BEGIN_WRITE, 2, 0, 0, 0);
    queue_request(KIND_UNUSED, 2, 0, 0, 0);
    wait_until_idle();

    // Zero capacity: only an empty payload may be published.
    write_config(CFG_PAYLOAD_CAPACITY, 32'd0);
    queue_request(KIND_PUBLISH, 2, 1, 64'h1234, 32'hA5A5_A5A5);
    queue_request(KIND_PUBLISH, 2, 0, 64'h1234, 32'hA5A5_A5A5);
    wait_until_idle();

    // Slot count zero rejects everything; counts above the table saturate.
    write_config(CFG_SLOTS_IN_USE, 32'd0);
    queue_request(KIND_QUERY, 0, 0, 0, 0);
    wait_until_idle();
    write_config(CFG_SLOTS_IN_USE, 32'd127);
    queue_request(KIND_QUERY, 63, 0, 0, 0);
    queue_request(KIND_QUERY, 64, 0, 0, 0);
    wait_until_idle();
    write_config(CFG_SLOTS_IN_USE, 32'd1);
    queue_request(KIND_QUERY, 0, 0, 0, 0);
    queue_request(KIND_QUERY, 1, 0, 0, 0);
    wait_until_idle();

    // Random traffic; the upper bits of the second slot count must be dropped.
    run_random_phase(32'd64, 32'hFFFF_FFFF, 24, 63, 1'b0);
    run_random_phase(32'hFFFF_FF85, 32'd0, 24, 63, 1'b0);
    run_random_phase(32'd1, 32'd1, 63, 24, 1'b1);
    run_random_phase(32'd127, 32'd1000, 63, 24, 1'b0);
    run_random_phase(32'd33, $urandom, 0, 0, 1'b0);
    run_random_phase(32'd64, 32'h8000_0000, 0, 0, 1'b0);

    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
design/sot_pkg.sv
design/sot_entry_store.sv
design/sot_cmd_logic.sv
design/slot_ownership_table_unit.sv
verif/slot_ownership_table_unit_tb.sv
